FILE: hw/rtl/trinrm_pkg.sv
// Shared widths and stage counts for the triangle unit normal pipeline.
`default_nettype none
package trinrm_pkg;
	localparam int CoordW = 16;
	localparam int DiffW  = 17;
	localparam int ProdW  = 34;
	localparam int MagW   = 34;
	localparam int NormW  = 31;
	localparam int SqW    = 62;
	localparam int SumW   = 64;
	localparam int RootW  = 32;
	localparam int RemW   = 34;
	localparam int NumW   = 46;
	localparam int QuoW   = 15;
	localparam int SqSteps  = 32;
	localparam int DivSteps = 15;
	localparam int OneQ14   = 16384;

	typedef logic [NormW-1:0] norm_t;
	typedef logic [NumW-1:0]  num_t;
endpackage
`default_nettype wire

FILE: hw/rtl/triangle_unit_normal.sv
// Top level: pipelined unit face normal of one triangle, Q8.8 in, Q1.14 out.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  input   | in_valid, in_stall, ax..cz                  | in
//  output  | out_valid, out_stall, nx, ny, nz, degenerate| out
//
// One request enters every cycle while the output is not stalled. The stages
// are 7 setup stages (differences, products, cross, max/leading bit, normalize,
// squares, sum), 32 square-root stages (one root bit each), a numerator stage,
// 15 divider stages (one quotient bit each) and the output register.
// Reset clears only the valid bits. A stall at the output with a request held
// there freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module triangle_unit_normal (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [trinrm_pkg::CoordW-1:0] ax,
	input  wire logic signed [trinrm_pkg::CoordW-1:0] ay,
	input  wire logic signed [trinrm_pkg::CoordW-1:0] az,
	input  wire logic signed [trinrm_pkg::CoordW-1:0] bx,
	input  wire logic signed [trinrm_pkg::CoordW-1:0] by,
	input  wire logic signed [trinrm_pkg::CoordW-1:0] bz,
	input  wire logic signed [trinrm_pkg::CoordW-1:0] cx,
	input  wire logic signed [trinrm_pkg::CoordW-1:0] cy,
	input  wire logic signed [trinrm_pkg::CoordW-1:0] cz,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [15:0] nx,
	output logic signed [15:0] ny,
	output logic signed [15:0] nz,
	output logic degenerate
);
	import trinrm_pkg::*;

	logic adv;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic sq_v_s [0:SqSteps];
	logic dv_v_s [0:DivSteps];

	// advance when the output register is empty or being taken
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: edge vectors
	logic signed [DiffW-1:0] u_s1 [3];
	logic signed [DiffW-1:0] w_s1 [3];
	// stage 2: partial products
	logic signed [ProdW-1:0] p_s2 [6];
	// stage 3: magnitudes and signs
	logic [MagW-1:0] m_s3 [3];
	logic [2:0]      neg_s3;
	// stage 4: top bit position
	logic [MagW-1:0] m_s4 [3];
	logic [2:0]      neg_s4;
	logic [5:0]      top_s4;
	logic            deg_s4;
	// stage 5: normalized magnitudes
	norm_t           m_s5 [3];
	logic [2:0]      neg_s5;
	logic            deg_s5;
	// stage 6: squares
	norm_t           m_s6 [3];
	logic [SqW-1:0]  sq_s6 [3];
	logic [2:0]      neg_s6;
	logic            deg_s6;

	// square-root pipeline, index 0 is the sum stage
	logic [SumW-1:0]  sq_rad_s  [0:SqSteps];
	logic [RemW-1:0]  sq_rem_s  [0:SqSteps];
	logic [RootW-1:0] sq_root_s [0:SqSteps];
	norm_t            sq_m_s    [0:SqSteps][3];
	logic [2:0]       sq_neg_s  [0:SqSteps];
	logic             sq_deg_s  [0:SqSteps];

	// divider pipeline, index 0 is the numerator stage
	num_t             dv_rem_s  [0:DivSteps][3];
	logic [RootW-1:0] dv_len_s  [0:DivSteps];
	logic [QuoW-1:0]  dv_q_s    [0:DivSteps][3];
	logic [2:0]       dv_neg_s  [0:DivSteps];
	logic             dv_deg_s  [0:DivSteps];

	// combinational helpers
	logic signed [ProdW:0] n_c [3];
	logic [MagW-1:0]       mx_c;
	logic [5:0]            top_c;

	always_comb begin
		n_c[0] = {p_s2[0][ProdW-1], p_s2[0]} - {p_s2[1][ProdW-1], p_s2[1]};
		n_c[1] = {p_s2[2][ProdW-1], p_s2[2]} - {p_s2[3][ProdW-1], p_s2[3]};
		n_c[2] = {p_s2[4][ProdW-1], p_s2[4]} - {p_s2[5][ProdW-1], p_s2[5]};
	end

	always_comb begin
		mx_c = m_s3[0];
		if (m_s3[1] > mx_c) mx_c = m_s3[1];
		if (m_s3[2] > mx_c) mx_c = m_s3[2];
		top_c = '0;
		for (int i = 0; i < MagW; i++) begin
			if (mx_c[i]) top_c = 6'(i);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0;
			for (int k = 0; k <= SqSteps; k++) sq_v_s[k] <= 1'b0;
			for (int k = 0; k <= DivSteps; k++) dv_v_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; sq_v_s[0] <= v_s6;
			for (int k = 0; k < SqSteps; k++) sq_v_s[k+1] <= sq_v_s[k];
			dv_v_s[0] <= sq_v_s[SqSteps];
			for (int k = 0; k < DivSteps; k++) dv_v_s[k+1] <= dv_v_s[k];
			out_valid <= dv_v_s[DivSteps];
		end
	end

	// front stages: differences, products, cross, max, normalize, squares, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1[0] <= DiffW'(ax) - DiffW'(bx);
			u_s1[1] <= DiffW'(ay) - DiffW'(by);
			u_s1[2] <= DiffW'(az) - DiffW'(bz);
			w_s1[0] <= DiffW'(cx) - DiffW'(ax);
			w_s1[1] <= DiffW'(cy) - DiffW'(ay);
			w_s1[2] <= DiffW'(cz) - DiffW'(az);

			p_s2[0] <= u_s1[1] * w_s1[2];
			p_s2[1] <= u_s1[2] * w_s1[1];
			p_s2[2] <= u_s1[2] * w_s1[0];
			p_s2[3] <= u_s1[0] * w_s1[2];
			p_s2[4] <= u_s1[0] * w_s1[1];
			p_s2[5] <= u_s1[1] * w_s1[0];

			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= n_c[i][ProdW];
				m_s3[i]   <= n_c[i][ProdW] ? MagW'(-n_c[i]) : MagW'(n_c[i]);
			end

			m_s4   <= m_s3;
			neg_s4 <= neg_s3;
			top_s4 <= top_c;
			deg_s4 <= (mx_c == '0);

			for (int i = 0; i < 3; i++) begin
				if (top_s4 >= 6'd30)
					m_s5[i] <= NormW'(m_s4[i] >> (top_s4 - 6'd30));
				else
					m_s5[i] <= NormW'(m_s4[i] << (6'd30 - top_s4));
			end
			neg_s5 <= neg_s4;
			deg_s5 <= deg_s4;

			for (int i = 0; i < 3; i++) sq_s6[i] <= m_s5[i] * m_s5[i];
			m_s6   <= m_s5;
			neg_s6 <= neg_s5;
			deg_s6 <= deg_s5;

			sq_rad_s[0]  <= SumW'(sq_s6[0]) + SumW'(sq_s6[1]) + SumW'(sq_s6[2]);
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_m_s[0]    <= m_s6;
			sq_neg_s[0]  <= neg_s6;
			sq_deg_s[0]  <= deg_s6;
		end
	end

	// square root: one root bit per stage
	for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
		logic [RemW+1:0] rsh;
		logic [RemW+1:0] trial;
		logic            take;
		always_comb begin
			rsh   = {sq_rem_s[k], sq_rad_s[k][SumW-1 -: 2]};
			trial = {2'b00, sq_root_s[k], 2'b01};
			take  = (rsh >= trial);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rad_s[k+1]  <= sq_rad_s[k] << 2;
				sq_rem_s[k+1]  <= take ? RemW'(rsh - trial) : RemW'(rsh);
				sq_root_s[k+1] <= {sq_root_s[k][RootW-2:0], take};
				sq_m_s[k+1]    <= sq_m_s[k];
				sq_neg_s[k+1]  <= sq_neg_s[k];
				sq_deg_s[k+1]  <= sq_deg_s[k];
			end
		end
	end

	// numerator with rounding half of the length
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= {sq_m_s[SqSteps][i], 14'b0}
					+ NumW'(sq_root_s[SqSteps] >> 1);
				dv_q_s[0][i]   <= '0;
			end
			dv_len_s[0] <= sq_root_s[SqSteps];
			dv_neg_s[0] <= sq_neg_s[SqSteps];
			dv_deg_s[0] <= sq_deg_s[SqSteps];
		end
	end

	// divider: one quotient bit per stage, most significant first
	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		num_t dsh;
		assign dsh = NumW'(dv_len_s[j]) << (DivSteps - 1 - j);
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_rem_s[j][i] >= dsh) begin
						dv_rem_s[j+1][i] <= dv_rem_s[j][i] - dsh;
						dv_q_s[j+1][i]   <= dv_q_s[j][i] | QuoW'(1 << (DivSteps - 1 - j));
					end else begin
						dv_rem_s[j+1][i] <= dv_rem_s[j][i];
						dv_q_s[j+1][i]   <= dv_q_s[j][i];
					end
				end
				dv_len_s[j+1] <= dv_len_s[j];
				dv_neg_s[j+1] <= dv_neg_s[j];
				dv_deg_s[j+1] <= dv_deg_s[j];
			end
		end
	end

	// output register: clamp, sign, zero on degenerate
	logic [15:0] res_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res_c[i] = {1'b0, dv_q_s[DivSteps][i]};
			if (res_c[i] > 16'(OneQ14)) res_c[i] = 16'(OneQ14);
			if (dv_neg_s[DivSteps][i]) res_c[i] = -res_c[i];
			if (dv_deg_s[DivSteps]) res_c[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx <= res_c[0];
			ny <= res_c[1];
			nz <= res_c[2];
			degenerate <= dv_deg_s[DivSteps];
		end
	end
endmodule
`default_nettype wire

FILE: test/tb_triangle_unit_normal.sv
// Testbench for the triangle unit normal pipeline: random and directed triangles, scoreboard check.
`timescale 1ns / 1ps
`default_nettype none
module tb_triangle_unit_normal;
	import trinrm_pkg::*;

	typedef struct packed {
		logic signed [CoordW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	} tri_t;
	typedef struct packed {
		logic signed [15:0] nx, ny, nz;
		logic degenerate;
	} nrm_t;

	localparam int Latency = 56;
	localparam int CycleLimit = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CoordW-1:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
	logic signed [CoordW-1:0] cx = '0, cy = '0, cz = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] nx, ny, nz;
	logic degenerate;

	tri_t tri_pending[$];
	nrm_t normal_expected[$];
	int errors = 0;
	int degen_seen = 0;
	int results_seen = 0;
	int cycles = 0;
	bit hold_sender = 1'b0;
	bit feeding_done = 1'b0;

	triangle_unit_normal dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
		.cx(cx), .cy(cy), .cz(cz),
		.out_valid(out_valid), .out_stall(out_stall),
		.nx(nx), .ny(ny), .nz(nz), .degenerate(degenerate)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Integer square root, floor.
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Compute the Q1.14 unit face normal of one triangle.
	function automatic nrm_t face_normal(input tri_t t);
		logic signed [63:0] u[3], w[3], n[3];
		logic [63:0] m[3], mx, s2, len, q;
		logic signed [15:0] comp[3];
		nrm_t r;
		u[0] = 64'(t.ax) - 64'(t.bx);
		u[1] = 64'(t.ay) - 64'(t.by);
		u[2] = 64'(t.az) - 64'(t.bz);
		w[0] = 64'(t.cx) - 64'(t.ax);
		w[1] = 64'(t.cy) - 64'(t.ay);
		w[2] = 64'(t.cz) - 64'(t.az);
		n[0] = u[1] * w[2] - u[2] * w[1];
		n[1] = u[2] * w[0] - u[0] * w[2];
		n[2] = u[0] * w[1] - u[1] * w[0];
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			r = '0;
			r.degenerate = 1'b1;
			return r;
		end
		while (mx >= (64'd1 << 31)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
		end
		while (mx < (64'd1 << 30)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
		end
		s2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = root_floor(s2);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * OneQ14 + (len >> 1)) / len;
			if (q > OneQ14) q = OneQ14;
			if (n[i] < 0) q = 64'd0 - q;
			comp[i] = q[15:0];
		end
		r.nx = comp[0];
		r.ny = comp[1];
		r.nz = comp[2];
		r.degenerate = 1'b0;
		return r;
	endfunction

	function automatic logic signed [15:0] rand_coord(input int spread);
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'sh8000 + 16'($urandom_range(0, 3));
			2: return 16'sh7fff - 16'($urandom_range(0, 3));
			default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	// Build a terrain-like triangle: grid point, row and column neighbors.
	function automatic tri_t grid_triangle();
		tri_t t;
		int stepv;
		stepv = $urandom_range(1, 1024);
		t.ax = 16'($urandom);
		t.ay = 16'($urandom);
		t.az = 16'($urandom);
		t.bx = t.ax + 16'(stepv);
		t.by = t.ay;
		t.bz = t.az + 16'($signed($urandom_range(0, 4096)) - 2048);
		t.cx = t.ax;
		t.cy = t.ay + 16'(stepv);
		t.cz = t.az + 16'($signed($urandom_range(0, 4096)) - 2048);
		return t;
	endfunction

	// Drive requests at the falling edge, in bursts with gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		tri_t t;
		if (arst_n && !(in_valid && in_stall)) begin
			if (in_valid) void'(tri_pending.pop_front());
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (tri_pending.size() > 0 && !hold_sender) begin
				burst_left--;
				t = tri_pending[0];
				{ax, ay, az, bx, by, bz, cx, cy, cz} <= t;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern: long free runs mixed with random stalling.
	always @(negedge clk) begin
		if ((cycles / 500) % 3 == 0) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 2) == 0);
	end

	// Predict on acceptance, check results on acceptance.
	always @(posedge clk) begin
		nrm_t e;
		cycles++;
		if (in_valid && !in_stall)
			normal_expected.push_back(face_normal({ax, ay, az, bx, by, bz, cx, cy, cz}));
		if (out_valid && !out_stall) begin
			results_seen++;
			if (degenerate) degen_seen++;
			if (normal_expected.size() == 0) begin
				$display("%0t: unexpected result nx=%0d ny=%0d nz=%0d deg=%0b",
					$time, nx, ny, nz, degenerate);
				errors++;
			end else begin
				e = normal_expected.pop_front();
				if (nx !== e.nx) begin
					$display("%0t: nx expected %0d actual %0d", $time, e.nx, nx);
					errors++;
				end
				if (ny !== e.ny) begin
					$display("%0t: ny expected %0d actual %0d", $time, e.ny, ny);
					errors++;
				end
				if (nz !== e.nz) begin
					$display("%0t: nz expected %0d actual %0d", $time, e.nz, nz);
					errors++;
				end
				if (degenerate !== e.degenerate) begin
					$display("%0t: degenerate expected %0b actual %0b",
						$time, e.degenerate, degenerate);
					errors++;
				end
			end
		end
	end

	// Abort on timeout.
	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("triangle_unit_normal regression: fail");
			$finish;
		end
	end

	initial begin
		tri_t t;
		// Directed: zero, collinear, extremes, axis-aligned faces.
		tri_pending.push_back('0);
		t = '0; t.ax = 16'sh7fff; t.bx = 16'sh7fff; t.cx = 16'sh7fff;
		tri_pending.push_back(t);
		t = '0; t.bx = 16'sd256; t.cx = 16'sd512;
		tri_pending.push_back(t);
		t = '0; t.bx = 16'sd256; t.cy = 16'sd256;
		tri_pending.push_back(t);
		t = '0; t.by = 16'sd256; t.cz = 16'sd256;
		tri_pending.push_back(t);
		t = '0; t.bz = 16'sd256; t.cx = 16'sd256;
		tri_pending.push_back(t);
		t = '0; t.bz = 16'sd1; t.cx = 16'sd1;
		tri_pending.push_back(t);
		t = {16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh8000, 16'sh8000};
		tri_pending.push_back(t);
		t = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh8000, 16'sh7fff, 16'sh7fff};
		tri_pending.push_back(t);
		t = {16'sh7fff, 16'sh8000, 16'sh0, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh0, 16'sh0, 16'sh8000};
		tri_pending.push_back(t);
		t = '1;
		tri_pending.push_back(t);
		t = {16'sh1, 16'sh1, 16'sh1, 16'sh0, 16'sh1, 16'sh1, 16'sh1, 16'sh0, 16'sh2};
		tri_pending.push_back(t);
		for (int i = 0; i < 6; i++) tri_pending.push_back(grid_triangle());
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		// Random: mostly grid triangles, some raw noise and collinear sets.
		for (int i = 0; i < 400; i++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					t.ax = rand_coord(300); t.ay = rand_coord(300); t.az = rand_coord(300);
					t.bx = rand_coord(300); t.by = rand_coord(300); t.bz = rand_coord(300);
					t.cx = rand_coord(300); t.cy = rand_coord(300); t.cz = rand_coord(300);
				end
				2: begin
					t = grid_triangle();
					t.cx = t.ax + (t.ax - t.bx);
					t.cy = t.ay + (t.ay - t.by);
					t.cz = t.az + (t.az - t.bz);
				end
				default: t = grid_triangle();
			endcase
			tri_pending.push_back(t);
			if (i == 200) begin
				// Let the pipeline drain completely before continuing.
				wait (tri_pending.size() == 0);
				hold_sender = 1'b1;
				wait (normal_expected.size() == 0);
				hold_sender = 1'b0;
			end
		end
		wait (tri_pending.size() == 0 && !in_valid);
		wait (normal_expected.size() == 0);
		repeat (Latency + 20) @(posedge clk);
		$display("checked %0d normals, %0d degenerate, directed extremes and grid faces",
			results_seen, degen_seen);
		if (errors == 0) $display("triangle_unit_normal regression: pass");
		else $display("triangle_unit_normal regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/trinrm_pkg.sv
hw/rtl/triangle_unit_normal.sv
test/tb_triangle_unit_normal.sv
